// ===== src/gnht_pkg.sv =====
// shared types and constants for the group next-hop table
// no dependencies
package gnht_pkg;

  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int MAX_HOPS_DEF    = 8;
  localparam int SLOT_FIELD_W    = 10;
  localparam int COUNT_FIELD_W   = 4;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_REM_DEST = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_LIST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] dest_key;
    logic [31:0] hop_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic [COUNT_FIELD_W-1:0] hop_count;
  } res_t;

  typedef enum logic [3:0] {
    ACT_NEW,
    ACT_APPEND,
    ACT_PRESENT,
    ACT_LIST_FULL,
    ACT_TABLE_FULL,
    ACT_NO_KEY,
    ACT_NO_HOP,
    ACT_DELETE,
    ACT_DEC
  } act_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_HOP_RD,
    S_HOP_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic slot_rd;
    logic scan_chk;
    logic hop_rd;
    logic hop_chk;
    logic shift_rd;
    logic shift_wr;
    logic commit;
    act_t act;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       idx_last;
    logic       slot_hit;
    logic       hop_hit;
    logic       hop_end;
    logic       shift_end;
    logic       found;
    logic       free_found;
    logic       hit;
    logic       cnt_full;
    logic       cnt_le1;
    logic       out_free;
  } stat_t;

endpackage

// ===== src/group_next_hop_table.sv =====
// top level of the group next-hop table: controller plus datapath
// depends on gnht_pkg, gnht_ctrl, gnht_dp
//
// Maps a 32-bit group key to an ordered list of up to MAX_HOPS distinct
// next hops, one result per request. After reset the block sweeps the slot
// valid memory and takes no request meanwhile. A request then reads the
// slots in turn for the key scan, stopping at the matching slot, compares
// the stored hops one by one, and on a remove moves each later hop up.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken.
module group_next_hop_table #(
  parameter int TABLE_SLOTS = gnht_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_HOPS    = gnht_pkg::MAX_HOPS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  gnht_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output gnht_pkg::res_t out_res
);
  import gnht_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gnht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gnht_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_HOPS    (MAX_HOPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in work");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != ST_DONE |-> out_res.slot == '0)
    else $error("failed request reports a slot");

  a_table_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status == ST_TABLE_FULL |-> out_res.hop_count == '0)
    else $error("table full with nonzero hop count");

endmodule

// ===== src/gnht_ctrl.sv =====
// controller state machine of the group next-hop table
// depends on gnht_pkg
module gnht_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gnht_pkg::stat_t  stat,
  output gnht_pkg::cmd_t   cmd
);
  import gnht_pkg::*;

  state_t state_r, state_nxt;
  act_t   act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    act = ACT_NO_KEY;
    case (stat.op)
      OP_ADD: begin
        if (!stat.found) act = stat.free_found ? ACT_NEW : ACT_TABLE_FULL;
        else if (stat.hit) act = ACT_PRESENT;
        else if (stat.cnt_full) act = ACT_LIST_FULL;
        else act = ACT_APPEND;
      end
      OP_REMOVE: begin
        if (!stat.found) act = ACT_NO_KEY;
        else if (!stat.hit) act = ACT_NO_HOP;
        else if (stat.cnt_le1) act = ACT_DELETE;
        else act = ACT_DEC;
      end
      OP_REM_DEST: act = stat.found ? ACT_DELETE : ACT_NO_KEY;
      default: act = ACT_NO_KEY;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.act   = act;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.idx_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SLOT_RD;
        end
      end
      S_SLOT_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        cmd.scan_chk = 1'b1;
        if (stat.slot_hit) begin
          state_nxt = (stat.op == OP_ADD || stat.op == OP_REMOVE) ? S_HOP_RD : S_FINISH;
        end else if (stat.idx_last) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SLOT_RD;
        end
      end
      S_HOP_RD: begin
        if (stat.hop_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.hop_rd = 1'b1;
          state_nxt  = S_HOP_CHK;
        end
      end
      S_HOP_CHK: begin
        cmd.hop_chk = 1'b1;
        if (stat.hop_hit) begin
          state_nxt = (stat.op == OP_REMOVE && !stat.cnt_le1) ? S_SHIFT_RD : S_FINISH;
        end else begin
          state_nxt = S_HOP_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat.shift_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_RD;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ===== src/gnht_dp.sv =====
// datapath of the group next-hop table: slot and hop memories, scan counters,
// result register; depends on gnht_pkg
module gnht_dp #(
  parameter int TABLE_SLOTS = gnht_pkg::TABLE_SLOTS_DEF,
  parameter int MAX_HOPS    = gnht_pkg::MAX_HOPS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gnht_pkg::req_t  in_req,
  input  gnht_pkg::cmd_t  cmd,
  output gnht_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output gnht_pkg::res_t  out_res
);
  import gnht_pkg::*;

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(MAX_HOPS + 1);
  localparam int AW = $clog2(TABLE_SLOTS * MAX_HOPS) < 1 ? 1 :
                      $clog2(TABLE_SLOTS * MAX_HOPS);

  logic          v_mem [TABLE_SLOTS];
  logic [31:0]   k_mem [TABLE_SLOTS];
  logic [CW-1:0] c_mem [TABLE_SLOTS];
  logic [31:0]   h_mem [TABLE_SLOTS * MAX_HOPS];

  logic          v_q;
  logic [31:0]   k_q;
  logic [CW-1:0] c_q;
  logic [31:0]   h_q;

  req_t          req_r;
  logic [SW-1:0] idx_r, slot_r, free_r;
  logic [CW-1:0] cnt_r, hidx_r;
  logic          found_r, free_found_r, hit_r, out_valid_r;
  res_t          res_r, res_nxt;

  logic          sv_we, skc_we, sv_wd, h_we, h_re;
  logic [SW-1:0] s_wa;
  logic [CW-1:0] c_wd;
  logic [AW-1:0] h_wa, h_ra, base;
  logic [31:0]   h_wd;
  logic [SW-1:0] hop_slot;

  assign hop_slot = (cmd.act == ACT_NEW) ? free_r : slot_r;
  assign base     = AW'(AW'(hop_slot) * AW'(MAX_HOPS));

  assign stat.op         = req_r.op;
  assign stat.idx_last   = idx_r == SW'(TABLE_SLOTS - 1);
  assign stat.slot_hit   = v_q && (k_q == req_r.dest_key);
  assign stat.hop_hit    = h_q == req_r.hop_addr;
  assign stat.hop_end    = hidx_r >= cnt_r;
  assign stat.shift_end  = (CW + 1)'(hidx_r) + 1'b1 >= (CW + 1)'(cnt_r);
  assign stat.found      = found_r;
  assign stat.free_found = free_found_r;
  assign stat.hit        = hit_r;
  assign stat.cnt_full   = cnt_r >= CW'(MAX_HOPS);
  assign stat.cnt_le1    = cnt_r <= CW'(1);
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    sv_we  = 1'b0;
    skc_we = 1'b0;
    sv_wd  = 1'b1;
    s_wa   = slot_r;
    c_wd   = cnt_r;
    h_we   = 1'b0;
    h_wa   = AW'(base + AW'(hidx_r));
    h_wd   = h_q;
    h_re   = cmd.hop_rd || cmd.shift_rd;
    h_ra   = cmd.shift_rd ? AW'(base + AW'(hidx_r) + 1'b1) : AW'(base + AW'(hidx_r));
    res_nxt = '0;
    if (cmd.shift_wr) h_we = 1'b1;
    case (cmd.act)
      ACT_NEW: begin
        s_wa = free_r;
        c_wd = CW'(1);
        h_wa = base;
        h_wd = req_r.hop_addr;
        res_nxt.status    = ST_DONE;
        res_nxt.slot      = SLOT_FIELD_W'(free_r);
        res_nxt.hop_count = COUNT_FIELD_W'(1);
      end
      ACT_APPEND: begin
        c_wd = CW'(cnt_r + 1'b1);
        h_wa = AW'(base + AW'(cnt_r));
        h_wd = req_r.hop_addr;
        res_nxt.status    = ST_DONE;
        res_nxt.slot      = SLOT_FIELD_W'(slot_r);
        res_nxt.hop_count = COUNT_FIELD_W'(CW'(cnt_r + 1'b1));
      end
      ACT_PRESENT: begin
        res_nxt.status    = ST_DONE;
        res_nxt.slot      = SLOT_FIELD_W'(slot_r);
        res_nxt.hop_count = COUNT_FIELD_W'(cnt_r);
      end
      ACT_LIST_FULL: begin
        res_nxt.status    = ST_LIST_FULL;
        res_nxt.hop_count = COUNT_FIELD_W'(cnt_r);
      end
      ACT_TABLE_FULL: res_nxt.status = ST_TABLE_FULL;
      ACT_NO_HOP: begin
        res_nxt.status    = ST_NOT_FOUND;
        res_nxt.hop_count = COUNT_FIELD_W'(cnt_r);
      end
      ACT_DELETE: begin
        sv_wd          = 1'b0;
        res_nxt.status = ST_DONE;
        res_nxt.slot   = SLOT_FIELD_W'(slot_r);
      end
      ACT_DEC: begin
        c_wd = CW'(cnt_r - 1'b1);
        res_nxt.status    = ST_DONE;
        res_nxt.slot      = SLOT_FIELD_W'(slot_r);
        res_nxt.hop_count = COUNT_FIELD_W'(CW'(cnt_r - 1'b1));
      end
      default: res_nxt.status = ST_NOT_FOUND;
    endcase
    if (cmd.clr_wr) begin
      sv_we = 1'b1;
      sv_wd = 1'b0;
      s_wa  = idx_r;
    end
    if (cmd.commit) begin
      case (cmd.act)
        ACT_NEW, ACT_APPEND: begin
          sv_we  = 1'b1;
          skc_we = 1'b1;
          h_we   = 1'b1;
        end
        ACT_DEC: begin
          sv_we  = 1'b1;
          skc_we = 1'b1;
        end
        ACT_DELETE: sv_we = 1'b1;
        default: sv_we = 1'b0;
      endcase
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (sv_we) v_mem[s_wa] <= sv_wd;
    if (skc_we) begin
      k_mem[s_wa] <= req_r.dest_key;
      c_mem[s_wa] <= c_wd;
    end
    if (cmd.slot_rd) begin
      v_q <= v_mem[idx_r];
      k_q <= k_mem[idx_r];
      c_q <= c_mem[idx_r];
    end
  end

  // hop memory
  always_ff @(posedge clk) begin
    if (h_we) h_mem[h_wa] <= h_wd;
    if (h_re) h_q <= h_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr || cmd.scan_chk) idx_r <= stat.idx_last ? '0 : SW'(idx_r + 1'b1);
      if (cmd.capture) idx_r <= '0;
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r        <= in_req;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      hit_r        <= 1'b0;
      hidx_r       <= '0;
    end
    if (cmd.scan_chk) begin
      if (stat.slot_hit) begin
        found_r <= 1'b1;
        slot_r  <= idx_r;
        cnt_r   <= c_q;
      end
      if (!v_q && !free_found_r) begin
        free_found_r <= 1'b1;
        free_r       <= idx_r;
      end
    end
    if (cmd.hop_chk) begin
      if (stat.hop_hit) hit_r <= 1'b1;
      else hidx_r <= CW'(hidx_r + 1'b1);
    end
    if (cmd.shift_wr) hidx_r <= CW'(hidx_r + 1'b1);
    if (cmd.commit) res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule
